### sv/lkvt_pkg.sv
// Package for the linear key/value table.
// Holds the default table size, field widths, operation codes and status codes.
// No dependencies.
package lkvt_pkg;

   // Default number of table entries
   localparam int unsigned ENTRIES_DEFAULT = 32;

   // Field widths fixed by the interface
   localparam int unsigned KEY_W    = 64;
   localparam int unsigned VALUE_W  = 64;
   localparam int unsigned STATUS_W = 3;

   typedef logic [STATUS_W-1:0] status_type;

   // Operation codes
   localparam logic OP_LOOKUP = 1'b0;
   localparam logic OP_STORE  = 1'b1;

   // Result status codes
   localparam status_type ST_HIT      = 3'd0;
   localparam status_type ST_MISS     = 3'd1;
   localparam status_type ST_UPDATED  = 3'd2;
   localparam status_type ST_INSERTED = 3'd3;
   localparam status_type ST_FULL     = 3'd4;

endpackage

### sv/linear_key_value_table.sv
// Linear key/value table: one module holding the key and value memories,
// the fill count and the scan sequencer. Depends on lkvt_pkg.
//
// The scan reads the valid entries in order through registered read ports and
// compares each word read with the held key; a hit, or the end of the valid
// entries, sets the registered result strobe. Only one word is in flight at a
// time, one entry compared per cycle; busy drops as the result is shown, so
// the next word is taken at the edge ending it.
// Reset clears the state machine and fill count, not the memories; no stalls.
module linear_key_value_table #(
   parameter int unsigned ENTRIES = lkvt_pkg::ENTRIES_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic                           req_operation,
   input  logic [lkvt_pkg::KEY_W-1:0]     req_key,
   input  logic [lkvt_pkg::VALUE_W-1:0]   req_new_value,
   output logic                           rsp_strobe,
   output logic [lkvt_pkg::STATUS_W-1:0]  rsp_status,
   output logic [lkvt_pkg::VALUE_W-1:0]   rsp_read_value
);

   localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int unsigned CNT_W = $clog2(ENTRIES + 1);
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(ENTRIES);

   typedef enum logic {
      S_IDLE,
      S_SCAN
   } state_type;

   // Entries are never removed and inserts take the lowest free slot, so
   // entry i is valid exactly when i < count.
   logic [lkvt_pkg::KEY_W-1:0]   key_mem [ENTRIES];
   logic [lkvt_pkg::VALUE_W-1:0] val_mem [ENTRIES];

   state_type                    state_ff, state_in;
   logic [CNT_W-1:0]             count_ff, count_in;
   logic [CNT_W-1:0]             scan_ptr_ff, scan_ptr_in;
   logic                         pend_ff, pend_in;
   logic [IDX_W-1:0]             pend_idx_ff, pend_idx_in;
   logic                         op_ff, op_in;
   logic [lkvt_pkg::KEY_W-1:0]   key_ff, key_in;
   logic [lkvt_pkg::VALUE_W-1:0] new_val_ff, new_val_in;
   logic [lkvt_pkg::KEY_W-1:0]   key_rd_ff;
   logic [lkvt_pkg::VALUE_W-1:0] val_rd_ff;
   logic                         rsp_strobe_ff, rsp_strobe_in;
   lkvt_pkg::status_type         rsp_status_ff, rsp_status_in;
   logic [lkvt_pkg::VALUE_W-1:0] rsp_value_ff, rsp_value_in;

   logic                         accept;
   logic                         rd_issue;
   logic [IDX_W-1:0]             rd_addr;
   logic                         match;
   logic                         scan_done;
   logic                         has_room;
   logic                         key_we;
   logic                         val_we;
   logic [IDX_W-1:0]             wr_addr;

   assign busy           = (state_ff != S_IDLE);
   assign accept         = start && !busy;
   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_read_value = rsp_value_ff;

   // Scan control and compare against the word read last cycle
   assign rd_issue  = (state_ff == S_SCAN) && (scan_ptr_ff != count_ff);
   assign rd_addr   = scan_ptr_ff[IDX_W-1:0];
   assign match     = pend_ff && (key_rd_ff == key_ff);
   assign scan_done = (scan_ptr_ff == count_ff) && !pend_ff;
   assign has_room  = (count_ff != FULL_COUNT);

   // Next-state and write-back decisions
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      scan_ptr_in   = scan_ptr_ff;
      pend_in       = 1'b0;
      pend_idx_in   = pend_idx_ff;
      op_in         = op_ff;
      key_in        = key_ff;
      new_val_in    = new_val_ff;
      rsp_strobe_in = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      key_we        = 1'b0;
      val_we        = 1'b0;
      wr_addr       = pend_idx_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in       = req_operation;
               key_in      = req_key;
               new_val_in  = req_new_value;
               scan_ptr_in = '0;
               state_in    = S_SCAN;
            end
         end
         S_SCAN: begin
            if (match) begin
               rsp_strobe_in = 1'b1;
               state_in      = S_IDLE;
               if (op_ff == lkvt_pkg::OP_LOOKUP) begin
                  rsp_status_in = lkvt_pkg::ST_HIT;
                  rsp_value_in  = val_rd_ff;
               end else begin
                  rsp_status_in = lkvt_pkg::ST_UPDATED;
                  rsp_value_in  = '0;
                  val_we        = 1'b1;
                  wr_addr       = pend_idx_ff;
               end
            end else if (scan_done) begin
               rsp_strobe_in = 1'b1;
               rsp_value_in  = '0;
               state_in      = S_IDLE;
               if (op_ff == lkvt_pkg::OP_LOOKUP) begin
                  rsp_status_in = lkvt_pkg::ST_MISS;
               end else if (has_room) begin
                  rsp_status_in = lkvt_pkg::ST_INSERTED;
                  key_we        = 1'b1;
                  val_we        = 1'b1;
                  wr_addr       = count_ff[IDX_W-1:0];
                  count_in      = count_ff + CNT_W'(1);
               end else begin
                  rsp_status_in = lkvt_pkg::ST_FULL;
               end
            end else if (rd_issue) begin
               pend_in     = 1'b1;
               pend_idx_in = rd_addr;
               scan_ptr_in = scan_ptr_ff + CNT_W'(1);
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State machine and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         scan_ptr_ff   <= '0;
         pend_ff       <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         scan_ptr_ff   <= scan_ptr_in;
         pend_ff       <= pend_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      pend_idx_ff   <= pend_idx_in;
      op_ff         <= op_in;
      key_ff        <= key_in;
      new_val_ff    <= new_val_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
   end

   // Key memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (key_we) begin
         key_mem[wr_addr] <= key_ff;
      end
      key_rd_ff <= key_mem[rd_addr];
   end

   // Value memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (val_we) begin
         val_mem[wr_addr] <= new_val_ff;
      end
      val_rd_ff <= val_mem[rd_addr];
   end

   // Checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_COUNT)
      else $error("fill count exceeds table size");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("accepted word did not raise busy");

   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |-> (state_ff == S_IDLE))
      else $error("result shown while still scanning");

   a_pend_scan: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> (state_ff == S_SCAN) && (pend_idx_ff < count_ff[IDX_W-1:0] ||
         count_ff == FULL_COUNT || pend_idx_ff < IDX_W'(count_ff)))
      else $error("pending read outside the valid entries");

   a_zero_value: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff && (rsp_status_ff != lkvt_pkg::ST_HIT) |-> (rsp_value_ff == '0))
      else $error("nonzero read value on a non-hit result");

   a_insert_count: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff && (rsp_status_ff == lkvt_pkg::ST_INSERTED)
         |-> (count_ff == $past(count_ff) + CNT_W'(1)))
      else $error("insert did not raise the fill count");

endmodule

### tb/sv/testbench.sv
// Self-checking testbench for linear_key_value_table.
// Drives lookups and stores through start/busy and checks every result word
// against the row's own expected result or an in-bench model of the table. Depends on lkvt_pkg and the RTL.
module testbench;

   localparam int unsigned SLOTS      = lkvt_pkg::ENTRIES_DEFAULT;
   localparam int          RANDOM_OPS = 1900;
   localparam int          IDLE_LIMIT = 2000;
   localparam logic [lkvt_pkg::KEY_W-1:0] ONES = '1;

   typedef struct packed {
      lkvt_pkg::status_type         status;
      logic [lkvt_pkg::VALUE_W-1:0] read_value;
   } table_result_type;

   // One directed request; typed rows carry their own expected result
   typedef struct packed {
      logic                         op;
      logic [lkvt_pkg::KEY_W-1:0]   key;
      logic [lkvt_pkg::VALUE_W-1:0] value;
      bit                           typed;
      table_result_type             result;
   } probe_row_type;

   localparam int DIRECTED_ROWS = 18;

   logic                          clock;
   logic                          reset;
   logic                          start;
   logic                          busy;
   logic                          req_operation;
   logic [lkvt_pkg::KEY_W-1:0]    req_key;
   logic [lkvt_pkg::VALUE_W-1:0]  req_new_value;
   logic                          rsp_strobe;
   logic [lkvt_pkg::STATUS_W-1:0] rsp_status;
   logic [lkvt_pkg::VALUE_W-1:0]  rsp_read_value;

   // Bench copy of the table contents
   logic [lkvt_pkg::KEY_W-1:0]   kv_keys   [SLOTS];
   logic [lkvt_pkg::VALUE_W-1:0] kv_values [SLOTS];
   bit                           kv_valid  [SLOTS];
   int unsigned                  kv_count;

   table_result_type pending_results [$];
   int               failures;
   int               idle_cycles;
   bit               no_idle;

   probe_row_type directed_rows [DIRECTED_ROWS] = '{
      // empty table: both key extremes miss, new_value ignored on lookup
      '{lkvt_pkg::OP_LOOKUP, 64'h0, ONES, 1'b1, '{lkvt_pkg::ST_MISS, 64'h0}},
      '{lkvt_pkg::OP_LOOKUP, ONES,  64'h0, 1'b1, '{lkvt_pkg::ST_MISS, 64'h0}},
      // key zero is an ordinary key
      '{lkvt_pkg::OP_STORE,  64'h0, ONES, 1'b1, '{lkvt_pkg::ST_INSERTED, 64'h0}},
      '{lkvt_pkg::OP_LOOKUP, 64'h0, 64'h0, 1'b1, '{lkvt_pkg::ST_HIT, ONES}},
      '{lkvt_pkg::OP_STORE,  ONES,  64'h0, 1'b1, '{lkvt_pkg::ST_INSERTED, 64'h0}},
      '{lkvt_pkg::OP_LOOKUP, ONES,  ONES, 1'b1, '{lkvt_pkg::ST_HIT, 64'h0}},
      // overwrite an existing key
      '{lkvt_pkg::OP_STORE,  64'h0, 64'h0, 1'b1, '{lkvt_pkg::ST_UPDATED, 64'h0}},
      '{lkvt_pkg::OP_LOOKUP, 64'h0, ONES, 1'b1, '{lkvt_pkg::ST_HIT, 64'h0}},
      '{lkvt_pkg::OP_STORE,  64'h8000_0000_0000_0001, 64'hAAAA_AAAA_AAAA_AAAA, 1'b1,
        '{lkvt_pkg::ST_INSERTED, 64'h0}},
      // keys one bit away from stored ones must miss
      '{lkvt_pkg::OP_LOOKUP, 64'h8000_0000_0000_0000, ONES, 1'b1,
        '{lkvt_pkg::ST_MISS, 64'h0}},
      '{lkvt_pkg::OP_LOOKUP, 64'h0000_0000_0000_0001, ONES, 1'b1,
        '{lkvt_pkg::ST_MISS, 64'h0}},
      '{lkvt_pkg::OP_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFE, ONES, 1'b1,
        '{lkvt_pkg::ST_MISS, 64'h0}},
      '{lkvt_pkg::OP_STORE,  64'h5555_5555_5555_5555, 64'h5555_5555_5555_5555, 1'b0,
        '{lkvt_pkg::ST_HIT, 64'h0}},
      '{lkvt_pkg::OP_LOOKUP, 64'h5555_5555_5555_5555, 64'h0, 1'b0,
        '{lkvt_pkg::ST_HIT, 64'h0}},
      '{lkvt_pkg::OP_LOOKUP, 64'h8000_0000_0000_0001, 64'h0, 1'b0,
        '{lkvt_pkg::ST_HIT, 64'h0}},
      '{lkvt_pkg::OP_STORE,  64'h0, 64'h0123_4567_89AB_CDEF, 1'b0,
        '{lkvt_pkg::ST_HIT, 64'h0}},
      '{lkvt_pkg::OP_STORE,  ONES,  ONES, 1'b0, '{lkvt_pkg::ST_HIT, 64'h0}},
      '{lkvt_pkg::OP_LOOKUP, ONES,  64'h0, 1'b0, '{lkvt_pkg::ST_HIT, 64'h0}}
   };

   linear_key_value_table #(
      .ENTRIES(SLOTS)
   ) i_dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_operation  (req_operation),
      .req_key        (req_key),
      .req_new_value  (req_new_value),
      .rsp_strobe     (rsp_strobe),
      .rsp_status     (rsp_status),
      .rsp_read_value (rsp_read_value)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Table behavior: first matching valid entry, else lowest free entry
   function automatic table_result_type search_and_store(input logic op,
         input logic [lkvt_pkg::KEY_W-1:0] key,
         input logic [lkvt_pkg::VALUE_W-1:0] value);
      table_result_type res;
      int               hit_idx;
      int               free_idx;
      hit_idx  = -1;
      free_idx = -1;
      res      = '{lkvt_pkg::ST_MISS, '0};
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (kv_valid[i] && kv_keys[i] == key) hit_idx = i;
         if (!kv_valid[i]) free_idx = i;
      end
      if (op == lkvt_pkg::OP_LOOKUP) begin
         if (hit_idx >= 0) res = '{lkvt_pkg::ST_HIT, kv_values[hit_idx]};
      end else if (hit_idx >= 0) begin
         kv_values[hit_idx] = value;
         res.status = lkvt_pkg::ST_UPDATED;
      end else if (free_idx >= 0) begin
         kv_keys[free_idx]   = key;
         kv_values[free_idx] = value;
         kv_valid[free_idx]  = 1'b1;
         kv_count++;
         res.status = lkvt_pkg::ST_INSERTED;
      end else begin
         res.status = lkvt_pkg::ST_FULL;
      end
      return res;
   endfunction

   // Sender idle time: mostly none or short, a few long, some bursts with none
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_idle || r < 50) return 0;
      if (r < 90) return $urandom_range(1, 4);
      return $urandom_range(10, 60);
   endfunction

   // Random key: mostly stored keys or near misses of them, some all-zero or all-one keys, some fresh ones
   function automatic logic [lkvt_pkg::KEY_W-1:0] pick_key();
      int r;
      r = $urandom_range(0, 99);
      if (kv_count > 0 && r < 45) return kv_keys[$urandom_range(0, kv_count - 1)];
      if (kv_count > 0 && r < 60)
         return kv_keys[$urandom_range(0, kv_count - 1)] ^
                (64'h1 << $urandom_range(0, lkvt_pkg::KEY_W - 1));
      if (r < 65) return 64'h0;
      if (r < 70) return ONES;
      return {$urandom, $urandom};
   endfunction

   function automatic logic [lkvt_pkg::VALUE_W-1:0] pick_value();
      int r;
      r = $urandom_range(0, 19);
      if (r == 0) return '0;
      if (r == 1) return ONES;
      return {$urandom, $urandom};
   endfunction

   // Present one request word and hold it until the block takes it
   task automatic send_word(input logic op, input logic [lkvt_pkg::KEY_W-1:0] key,
         input logic [lkvt_pkg::VALUE_W-1:0] value, input bit typed,
         input table_result_type typed_result, input int gap);
      table_result_type predicted;
      start         <= 1'b1;
      req_operation <= op;
      req_key       <= key;
      req_new_value <= value;
      @(posedge clock);
      while (busy) @(posedge clock);
      predicted = search_and_store(op, key, value);
      pending_results.push_back(typed ? typed_result : predicted);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Result checker: each strobe is matched against the oldest expectation
   always @(posedge clock) begin
      table_result_type due;
      if (!reset && rsp_strobe === 1'b1) begin
         if (pending_results.size() == 0) begin
            $error("result word with none expected: status %0d read_value %h",
                   rsp_status, rsp_read_value);
            failures++;
         end else begin
            due = pending_results.pop_front();
            if (rsp_status !== due.status) begin
               $error("rsp_status: expected %0d, actual %0d", due.status, rsp_status);
               failures++;
            end
            if (rsp_read_value !== due.read_value) begin
               $error("rsp_read_value: expected %h, actual %h",
                      due.read_value, rsp_read_value);
               failures++;
            end
         end
      end
   end

   // Watchdog: too long with no word moving on either side
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe === 1'b1) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      logic op;
      reset         = 1'b1;
      start         = 1'b0;
      req_operation = lkvt_pkg::OP_LOOKUP;
      req_key       = '0;
      req_new_value = '0;
      failures      = 0;
      idle_cycles   = 0;
      no_idle       = 1'b0;
      kv_count      = 0;
      for (int i = 0; i < SLOTS; i++) begin
         kv_keys[i]   = '0;
         kv_values[i] = '0;
         kv_valid[i]  = 1'b0;
      end
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed rows
      foreach (directed_rows[i])
         send_word(directed_rows[i].op, directed_rows[i].key, directed_rows[i].value,
                   directed_rows[i].typed, directed_rows[i].result, pick_gap());

      // Random traffic; fills the table, then runs on it while full
      for (int n = 0; n < RANDOM_OPS; n++) begin
         if (n % 150 == 0) no_idle = ($urandom_range(0, 2) == 0);
         op = ($urandom_range(0, 1) == 1) ? lkvt_pkg::OP_STORE : lkvt_pkg::OP_LOOKUP;
         send_word(op, pick_key(), pick_value(), 1'b0, '0, pick_gap());
      end
      start <= 1'b0;

      // Drain, then watch a while longer for stray result words
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SLOTS + 10) @(posedge clock);
      if (failures == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
